### rtl/fpcc_pkg.sv
// Shared types, constants and AES helper functions for the frame payload
// counter cipher. No dependencies.
package fpcc_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int ROUNDS      = 10;

  typedef logic [127:0] block_t;
  typedef logic [4:0]   count_t;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_index_t;

  // side band carried along the round pipeline
  typedef struct packed {
    logic [127:0] payload;
    count_t       valid_bytes;
  } side_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    case (rnd)
      4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
      4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
      4'd9: r = 8'h1b; 4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input block_t b, input int i);
    return b[127-8*i -: 8];
  endfunction

  // next round key from the previous one
  function automatic block_t next_key(input block_t k, input logic [3:0] rnd);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t  = {sbox(w3[23:16]) ^ rcon(rnd), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

### rtl/fpcc_round.sv
// One AES round stage with its own key expansion step, registered.
// Depends on fpcc_pkg.
module fpcc_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [3:0]          rnd,
  input  logic                in_valid,
  input  fpcc_pkg::block_t    in_state,
  input  fpcc_pkg::block_t    in_key,
  input  fpcc_pkg::side_t     in_side,
  output logic                out_valid,
  output fpcc_pkg::block_t    out_state,
  output fpcc_pkg::block_t    out_key,
  output fpcc_pkg::side_t     out_side
);
  import fpcc_pkg::*;

  block_t sub, mixed, key_next;
  logic [7:0] a0, a1, a2, a3, x;

  always_comb begin
    sub = '0;
    mixed = '0;
    a0 = '0; a1 = '0; a2 = '0; a3 = '0; x = '0;
    // sub bytes and shift rows
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sub[127-8*(r+4*c) -: 8] = sbox(get_byte(in_state, r + 4*((c + r) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sub[127-32*c -: 8];
      a1 = sub[119-32*c -: 8];
      a2 = sub[111-32*c -: 8];
      a3 = sub[103-32*c -: 8];
      x  = a0 ^ a1 ^ a2 ^ a3;
      mixed[127-32*c -: 32] = {a0 ^ x ^ xtime(a0 ^ a1), a1 ^ x ^ xtime(a1 ^ a2),
                               a2 ^ x ^ xtime(a2 ^ a3), a3 ^ x ^ xtime(a3 ^ a0)};
    end
    key_next = next_key(in_key, rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // final round skips the column mix
      out_state <= ((rnd == 4'(ROUNDS)) ? sub : mixed) ^ key_next;
      out_key   <= key_next;
      out_side  <= in_side;
    end
  end

endmodule

### rtl/frame_payload_counter_cipher_unit.sv
// Top level of the frame payload counter cipher: key registers, counter block
// build, ten round stages and the masked output XOR. Depends on fpcc_pkg, fpcc_round.
// Each word passes through twelve register stages: one for the counter block
// and initial key add, one per AES round (each stage runs one round and one
// key expansion step), and the output register. One word is taken every cycle
// while the output is not stalled. The pipeline advances as a whole while the
// output is empty or being taken, so a stall on the output holds every stage. The
// key is read as the word enters, so change it only when the block is idle.
module frame_payload_counter_cipher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] payload_high,
  input  logic [63:0] payload_low,
  input  logic [4:0]  valid_bytes,
  input  logic [7:0]  block_number,
  input  logic        direction,
  input  logic [31:0] device_address,
  input  logic [31:0] frame_counter,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  output logic [4:0]  result_valid_bytes
);
  import fpcc_pkg::*;

  logic [63:0] key_high, key_low;
  logic        advance;

  logic   st_valid [ROUNDS+1];
  block_t st_state [ROUNDS+1];
  block_t st_key   [ROUNDS+1];
  side_t  st_side  [ROUNDS+1];

  block_t ctr, ks, masked;
  side_t  side_in;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // counter block: 01, four zeros, direction, address and counter little-endian, 00, block number
  assign ctr = {8'h01, 32'h0, 7'h0, direction,
                device_address[7:0], device_address[15:8],
                device_address[23:16], device_address[31:24],
                frame_counter[7:0], frame_counter[15:8],
                frame_counter[23:16], frame_counter[31:24],
                8'h00, block_number};
  assign side_in = '{payload: {payload_high, payload_low}, valid_bytes: valid_bytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (advance) begin
      st_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st_state[0] <= ctr ^ {key_high, key_low};
      st_key[0]   <= {key_high, key_low};
      st_side[0]  <= side_in;
    end
  end

  for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
    fpcc_round u_round (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .rnd       (4'(g)),
      .in_valid  (st_valid[g-1]),
      .in_state  (st_state[g-1]),
      .in_key    (st_key[g-1]),
      .in_side   (st_side[g-1]),
      .out_valid (st_valid[g]),
      .out_state (st_state[g]),
      .out_key   (st_key[g]),
      .out_side  (st_side[g])
    );
  end

  assign ks = st_state[ROUNDS];

  // zero the output bytes past the valid count; counts above sixteen cover the block
  always_comb begin
    masked = '0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (5'(i) < st_side[ROUNDS].valid_bytes) begin
        masked[127-8*i -: 8] = get_byte(ks, i) ^ get_byte(st_side[ROUNDS].payload, i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= st_valid[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_high        <= masked[127:64];
      result_low         <= masked[63:0];
      result_valid_bytes <= st_side[ROUNDS].valid_bytes;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_high) && $stable(result_low))
    else $error("output word changed under stall");

  a_no_input_under_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_pipe_moves: assert property (@(posedge clk) disable iff (rst)
    !out_stall |=> out_valid == $past(st_valid[ROUNDS]))
    else $error("last round stage not forwarded");

  a_zero_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_valid_bytes <= 5'd8 |-> result_low == 64'h0)
    else $error("bytes past valid count not cleared");

endmodule

### verif/frame_payload_counter_cipher_unit_tb.sv
// Testbench for frame_payload_counter_cipher_unit: drives payload words with random gaps,
// predicts each result with a behavioural AES-128 counter-mode model and checks in order.
// Depends on fpcc_pkg and the RTL top level.
`timescale 1ns / 1ps

module frame_payload_counter_cipher_unit_tb;
  import fpcc_pkg::*;

  typedef struct packed {
    logic [63:0] payload_high;
    logic [63:0] payload_low;
    logic [4:0]  valid_bytes;
    logic [7:0]  block_number;
    logic        direction;
    logic [31:0] device_address;
    logic [31:0] frame_counter;
  } word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  result_valid_bytes;
  } cipher_out_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall;
  word_t       drv;
  cipher_out_t got;

  logic [63:0] key_hi_m, key_lo_m;
  word_t       pending_words[$];
  cipher_out_t expected_results[$];
  int          in_gap;
  int          out_gap;
  int          mismatches;
  logic        drain_req;
  logic [7:0]  sb_tab[256];

  frame_payload_counter_cipher_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .payload_high(drv.payload_high), .payload_low(drv.payload_low),
    .valid_bytes(drv.valid_bytes), .block_number(drv.block_number),
    .direction(drv.direction), .device_address(drv.device_address),
    .frame_counter(drv.frame_counter),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_high(got.result_high), .result_low(got.result_low),
    .result_valid_bytes(got.result_valid_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // State and payload byte arrays indexed 0..15, byte 0 first, as in the counter block layout.
  function automatic cipher_out_t ctr_crypt(input word_t w);
    logic [7:0] rk[176];
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] p[16];
    logic [7:0] t0, t1, t2, t3, tmp, x, a0, a1, a2, a3;
    logic [7:0] rc;
    logic [127:0] kk, pp, res;
    int n;
    cipher_out_t o;
    kk = {key_hi_m, key_lo_m};
    pp = {w.payload_high, w.payload_low};
    for (int i = 0; i < 16; i++) begin
      rk[i] = kk[127-8*i -: 8];
      p[i]  = pp[127-8*i -: 8];
    end
    rc = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      t0 = rk[i-4]; t1 = rk[i-3]; t2 = rk[i-2]; t3 = rk[i-1];
      if ((i % 16) == 0) begin
        tmp = t0;
        t0 = sb_tab[t1] ^ rc;
        t1 = sb_tab[t2];
        t2 = sb_tab[t3];
        t3 = sb_tab[tmp];
        rc = dbl(rc);
      end
      rk[i] = rk[i-16] ^ t0; rk[i+1] = rk[i-15] ^ t1;
      rk[i+2] = rk[i-14] ^ t2; rk[i+3] = rk[i-13] ^ t3;
    end
    s[0] = 8'h01;
    for (int i = 1; i < 5; i++) s[i] = 8'h00;
    s[5] = {7'd0, w.direction};
    for (int i = 0; i < 4; i++) begin
      s[6+i]  = w.device_address[8*i +: 8];
      s[10+i] = w.frame_counter[8*i +: 8];
    end
    s[14] = 8'h00;
    s[15] = w.block_number;
    for (int i = 0; i < 16; i++) s[i] ^= rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++)
          t[j+4*c] = sb_tab[s[j + 4*((c+j) % 4)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ x ^ dbl(a0 ^ a1);
          t[4*c+1] = a1 ^ x ^ dbl(a1 ^ a2);
          t[4*c+2] = a2 ^ x ^ dbl(a2 ^ a3);
          t[4*c+3] = a3 ^ x ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
    end
    n = (w.valid_bytes > 16) ? 16 : w.valid_bytes;
    for (int i = 0; i < 16; i++)
      res[127-8*i -: 8] = (i < n) ? (p[i] ^ s[i]) : 8'h00;
    o.result_high = res[127:64];
    o.result_low = res[63:0];
    o.result_valid_bytes = w.valid_bytes;
    return o;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w.payload_high   = {$urandom, $urandom};
    w.payload_low    = {$urandom, $urandom};
    w.valid_bytes    = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
    w.block_number   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 15));
    w.direction      = 1'($urandom);
    w.device_address = $urandom;
    w.frame_counter  = $urandom;
    return w;
  endfunction

  // Driver: present the next pending word after a random gap; hold it while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (in_valid && !in_stall) begin
      expected_results.push_back(ctr_crypt(drv));
      if (pending_words.size() > 0 && !drain_req && $urandom_range(0, 3) == 0) begin
        drv <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      end
    end else if (!in_valid && pending_words.size() > 0 && !drain_req) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else begin
        drv      <= pending_words.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor: compare each taken result with the oldest expectation; random stall.
  always @(posedge clk) begin
    cipher_out_t want;
    int          gap;
    if (rst) begin
      out_stall <= 1'b0;
      out_gap   <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_results.pop_front();
        if (want !== got) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %h %h %0d, got %h %h %0d",
                     want.result_high, want.result_low, want.result_valid_bytes,
                     got.result_high, got.result_low, got.result_valid_bytes);
        end
      end
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
      out_stall <= (gap > 0);
      out_gap   <= (gap > 0) ? gap - 1 : 0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    drain_req = 1'b1;
    repeat (16) @(posedge clk);
  endtask

  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= REG_KEY_HIGH; cfg_data <= hi;
    @(posedge clk);
    cfg_index <= REG_KEY_LOW; cfg_data <= lo;
    @(posedge clk);
    cfg_write <= 1'b0;
    key_hi_m = hi;
    key_lo_m = lo;
  endtask

  task automatic run_phase(input int count);
    for (int i = 0; i < count; i++) pending_words.push_back(rand_word());
    drain_req = 1'b0;
    wait_idle();
  endtask

  initial begin
    word_t w;
    logic [7:0] sv;
    // build the S-box from the field inverse and the affine map
    for (int i = 0; i < 256; i++) begin
      logic [7:0] inv, b;
      inv = 8'h00;
      for (int j = 1; j < 256; j++) begin
        logic [7:0] pa, pb, pr;
        pa = 8'(i); pb = 8'(j); pr = 8'h00;
        for (int k = 0; k < 8; k++) begin
          if (pb[0]) pr ^= pa;
          pa = dbl(pa); pb = pb >> 1;
        end
        if (pr == 8'h01) inv = 8'(j);
      end
      b = inv;
      sv = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
           ^ {b[3:0], b[7:4]} ^ 8'h63;
      sb_tab[i] = sv;
    end
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = REG_KEY_HIGH; cfg_data = '0;
    in_valid = 1'b0; out_stall = 1'b0; drv = '0;
    mismatches = 0; drain_req = 1'b1;
    key_hi_m = '0; key_lo_m = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset key, field extremes, zero and oversize counts, block zero.
    w = '0; w.valid_bytes = 5'd16; w.block_number = 8'd1;
    pending_words.push_back(w);
    w = '1; w.valid_bytes = 5'd16; w.block_number = 8'd255;
    pending_words.push_back(w);
    for (int v = 0; v < 32; v += 3) begin
      w = rand_word(); w.valid_bytes = 5'(v); pending_words.push_back(w);
    end
    w = rand_word(); w.valid_bytes = 5'd31; w.block_number = 8'd0;
    pending_words.push_back(w);
    w = rand_word(); w.direction = 1'b0; w.device_address = '0; w.frame_counter = '1;
    pending_words.push_back(w);
    w = rand_word(); w.direction = 1'b1; w.device_address = '1; w.frame_counter = '0;
    pending_words.push_back(w);
    drain_req = 1'b0;
    wait_idle();

    write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    run_phase(180);
    write_key('1, '1);
    run_phase(150);
    write_key({$urandom, $urandom}, {$urandom, $urandom});
    run_phase(230);
    write_key('0, '1);
    run_phase(100);
    write_key({$urandom, $urandom}, {$urandom, $urandom});
    run_phase(90);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
